// ===== hdl/sobel_pkg.sv =====
// ============================================================================
// sobel_pkg: shared types and constants of the Sobel edge threshold block
// Holds the line store geometry, output queue sizing, register indexes,
// reset values and the structs passed between the modules.
// ============================================================================
`default_nettype none

package sobel_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int LINE_ADDR_W  = $clog2(MAX_WIDTH);
    localparam int COL_W        = 11;
    localparam int ROW_W        = 12;
    localparam int PIX_W        = 8;
    localparam int CFG_DATA_W   = 12;
    localparam int CFG_INDEX_W  = 2;
    localparam int FIFO_DEPTH   = 8;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W   = FIFO_PTR_W + 1;
    localparam int GRAD_W       = 11;
    localparam int SQ_W         = 20;
    localparam int THR_SQ_W     = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    localparam logic [THR_SQ_W-1:0] RST_THR_SQ = 16'd10000;
    localparam logic [COL_W-1:0]    RST_WLAST  = 11'd639;
    localparam logic [ROW_W-1:0]    RST_HLAST  = 12'd479;

    localparam logic [PIX_W-1:0] EDGE_ON  = 8'd255;
    localparam logic [PIX_W-1:0] EDGE_OFF = 8'd0;

    typedef struct packed {
        logic emit;
        logic last;
    } t_tag;

    typedef struct packed {
        logic [PIX_W-1:0] edge_value;
        logic             last;
    } t_res;

endpackage

`default_nettype wire

// ===== hdl/sobel_ram.sv =====
// ============================================================================
// sobel_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; a read of the address being
// written returns the old contents.
// ============================================================================
`default_nettype none

module sobel_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/sobel_kernel.sv =====
// ============================================================================
// sobel_kernel: 3x3 window, gradients and threshold test
// Shifts each column into the window, forms both gradients, squares them in
// the next stage and compares the sum with the squared threshold.
// ============================================================================
`default_nettype none

module sobel_kernel
    import sobel_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire logic [PIX_W-1:0]    i_top,
    input  wire logic [PIX_W-1:0]    i_mid,
    input  wire logic [PIX_W-1:0]    i_px,
    input  wire t_tag                i_tag,
    input  wire logic [THR_SQ_W-1:0] i_thr_sq,
    output logic                     o_res_valid,
    output t_res                     o_res,
    output logic [1:0]               o_inflight
);

    logic [PIX_W-1:0] r_win [6];
    logic [PIX_W-1:0] n_win [6];

    logic                     r_s2_valid;
    t_tag                     r_s2_tag;
    logic signed [GRAD_W-1:0] r_gx;
    logic signed [GRAD_W-1:0] r_gy;
    logic signed [GRAD_W-1:0] n_gx;
    logic signed [GRAD_W-1:0] n_gy;

    logic            r_s3_valid;
    t_tag            r_s3_tag;
    logic [SQ_W-1:0] r_gx2;
    logic [SQ_W-1:0] r_gy2;

    logic [9:0]               left_sum;
    logic [9:0]               right_sum;
    logic [9:0]               top_sum;
    logic [9:0]               bot_sum;
    logic signed [2*GRAD_W-1:0] gx_prod;
    logic signed [2*GRAD_W-1:0] gy_prod;
    logic [SQ_W:0]            mag2;

    always_comb begin
        left_sum  = {2'b0, r_win[0]} + {1'b0, r_win[1], 1'b0} + {2'b0, r_win[2]};
        right_sum = {2'b0, i_top} + {1'b0, i_mid, 1'b0} + {2'b0, i_px};
        top_sum   = {2'b0, r_win[0]} + {1'b0, r_win[3], 1'b0} + {2'b0, i_top};
        bot_sum   = {2'b0, r_win[2]} + {1'b0, r_win[5], 1'b0} + {2'b0, i_px};
        n_gx      = $signed({1'b0, left_sum}) - $signed({1'b0, right_sum});
        n_gy      = $signed({1'b0, top_sum}) - $signed({1'b0, bot_sum});
        n_win[0]  = r_win[3];
        n_win[1]  = r_win[4];
        n_win[2]  = r_win[5];
        n_win[3]  = i_top;
        n_win[4]  = i_mid;
        n_win[5]  = i_px;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (i_valid) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= n_win[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_gx     <= n_gx;
        r_gy     <= n_gy;
        r_s2_tag <= i_tag;
    end

    assign gx_prod = r_gx * r_gx;
    assign gy_prod = r_gy * r_gy;

    always_ff @(posedge i_clk) begin
        r_gx2    <= gx_prod[SQ_W-1:0];
        r_gy2    <= gy_prod[SQ_W-1:0];
        r_s3_tag <= r_s2_tag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s2_valid <= i_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    assign mag2 = {1'b0, r_gx2} + {1'b0, r_gy2};

    always_comb begin
        o_res_valid        = r_s3_valid && r_s3_tag.emit;
        o_res.edge_value   = (mag2 > {{(SQ_W + 1 - THR_SQ_W){1'b0}}, i_thr_sq})
                             ? EDGE_ON : EDGE_OFF;
        o_res.last         = r_s3_tag.last;
        o_inflight         = {1'b0, r_s2_valid} + {1'b0, r_s3_valid};
    end

endmodule

`default_nettype wire

// ===== hdl/sobel_fifo.sv =====
// ============================================================================
// sobel_fifo: output queue of results
// A small register queue that decouples the result stream from the pipeline.
// ============================================================================
`default_nettype none

module sobel_fifo
    import sobel_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire t_res                  i_data,
    input  wire logic                  i_pop,
    output logic                       o_valid,
    output t_res                       o_data,
    output logic [FIFO_CNT_W-1:0]      o_count
);

    t_res                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wptr;
    logic [FIFO_PTR_W-1:0] r_rptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  pop_ok;

    assign pop_ok = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (pop_ok) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, pop_ok})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign o_count = r_count;

endmodule

`default_nettype wire

// ===== hdl/sobel_edge_threshold.sv =====
// ============================================================================
// sobel_edge_threshold: 3x3 Sobel edge detector with a magnitude threshold
// Marks each interior pixel of a raster frame as edge or background.
// ============================================================================
// Pixels enter on the s_axis channel in raster order, tuser set on the first
// pixel of a frame, which restarts the row and column counts. Results leave
// on the m_axis channel: tdata is 255 for an edge and 0 otherwise, tlast is
// set on the last result of the frame. Border pixels give no result, so a
// frame of H rows by W columns yields (H-2) x (W-2) items.
// The block takes one pixel per clock cycle while s_axis_tready is high.
// The result for the pixel completing a neighbourhood passes the first,
// gradient and square stages and the output queue. The two previous rows
// sit in one line store RAM read at the accepting edge and written back at
// the next edge; a same-address read and write is forwarded.
// Results collect in an eight-item output queue; when the receiver stalls,
// s_axis_tready falls once the queue and the pipeline together hold eight
// items, so nothing is lost. Configuration writes are always accepted and
// are meant to be made while the block is idle. Reset restores threshold
// 100, width 640 and height 480 and clears the counts, window and queue;
// the line store contents are not cleared.
// ============================================================================
`default_nettype none

module sobel_edge_threshold
    import sobel_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [PIX_W-1:0]       s_axis_tdata,   // [7:0] pixel
    input  wire logic                   s_axis_tuser,   // [0] frame_start
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [PIX_W-1:0]            m_axis_tdata,   // [7:0] edge_value
    output logic                        m_axis_tlast,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic [THR_SQ_W-1:0] r_thr_sq;
    logic [COL_W-1:0]    r_wlast;
    logic [ROW_W-1:0]    r_hlast;

    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;
    logic [COL_W-1:0] c_cur;
    logic [ROW_W-1:0] r_cur;
    logic             row_end;
    logic             frame_end;
    logic             accept;

    logic                   r_s1_valid;
    logic [LINE_ADDR_W-1:0] r_s1_addr;
    logic [PIX_W-1:0]       r_s1_px;
    t_tag                   r_s1_tag;
    t_tag                   n_tag;

    logic                   r_fwd_hit;
    logic [2*PIX_W-1:0]     r_fwd_data;
    logic [2*PIX_W-1:0]     ram_rdata;
    logic [2*PIX_W-1:0]     line_word;
    logic [2*PIX_W-1:0]     wdata;
    logic [PIX_W-1:0]       top;
    logic [PIX_W-1:0]       mid;

    logic                   res_valid;
    t_res                   res;
    logic [1:0]             inflight;
    t_res                   fifo_data;
    logic [FIFO_CNT_W-1:0]  fifo_count;
    logic [FIFO_CNT_W:0]    occupancy;
    logic [COL_W-1:0]       cfg_w;
    logic [ROW_W-1:0]       cfg_h;
    logic [THR_SQ_W-1:0]    cfg_sq;

    assign o_cfg_ready = 1'b1;
    assign cfg_w  = i_cfg_data[COL_W-1:0];
    assign cfg_h  = i_cfg_data[ROW_W-1:0];
    assign cfg_sq = THR_SQ_W'(i_cfg_data[PIX_W-1:0]) * THR_SQ_W'(i_cfg_data[PIX_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_sq <= RST_THR_SQ;
            r_wlast  <= RST_WLAST;
            r_hlast  <= RST_HLAST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_THRESHOLD: begin
                    r_thr_sq <= cfg_sq;
                end
                CFG_IMAGE_WIDTH: begin
                    if (cfg_w < COL_W'(3)) begin
                        r_wlast <= COL_W'(2);
                    end else if (cfg_w > COL_W'(MAX_WIDTH)) begin
                        r_wlast <= COL_W'(MAX_WIDTH - 1);
                    end else begin
                        r_wlast <= cfg_w - 1'b1;
                    end
                end
                CFG_IMAGE_HEIGHT: begin
                    if (cfg_h < ROW_W'(3)) begin
                        r_hlast <= ROW_W'(2);
                    end else begin
                        r_hlast <= cfg_h - 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign occupancy     = {1'b0, fifo_count} + (FIFO_CNT_W + 1)'(r_s1_valid)
                           + (FIFO_CNT_W + 1)'(inflight);
    assign s_axis_tready = (occupancy < (FIFO_CNT_W + 1)'(FIFO_DEPTH));
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        c_cur     = s_axis_tuser ? '0 : r_col;
        r_cur     = s_axis_tuser ? '0 : r_row;
        row_end   = (c_cur >= r_wlast);
        frame_end = row_end && (r_cur >= r_hlast);
        n_col     = row_end ? '0 : c_cur + 1'b1;
        n_row     = frame_end ? '0 : (row_end ? r_cur + 1'b1 : r_cur);
        n_tag.emit = (r_cur >= ROW_W'(2)) && (c_cur >= COL_W'(2));
        n_tag.last = frame_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_addr  <= c_cur[LINE_ADDR_W-1:0];
            r_s1_px    <= s_axis_tdata;
            r_s1_tag   <= n_tag;
            r_fwd_hit  <= r_s1_valid && (r_s1_addr == c_cur[LINE_ADDR_W-1:0]);
            r_fwd_data <= wdata;
        end
    end

    assign line_word = r_fwd_hit ? r_fwd_data : ram_rdata;
    assign top       = line_word[2*PIX_W-1:PIX_W];
    assign mid       = line_word[PIX_W-1:0];
    assign wdata     = {mid, r_s1_px};

    sobel_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_addr),
        .i_wdata (wdata),
        .i_re    (accept),
        .i_raddr (c_cur[LINE_ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    sobel_kernel u_kernel (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_s1_valid),
        .i_top       (top),
        .i_mid       (mid),
        .i_px        (r_s1_px),
        .i_tag       (r_s1_tag),
        .i_thr_sq    (r_thr_sq),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_inflight  (inflight)
    );

    sobel_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .i_pop   (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (fifo_data),
        .o_count (fifo_count)
    );

    assign m_axis_tdata = fifo_data.edge_value;
    assign m_axis_tlast = fifo_data.last;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(res_valid && (fifo_count == FIFO_CNT_W'(FIFO_DEPTH)) && !m_axis_tready))
        else $error("output queue overflow");

    a_accept_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted item missing from first stage");

    a_fwd_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_fwd_hit) |-> $past(r_s1_valid))
        else $error("forward hit without a preceding write");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col < COL_W'(MAX_WIDTH))
        else $error("column count beyond line store");

endmodule

`default_nettype wire
